@@ hdl/assert_macros.svh @@
// assertion macros used by the scheduler table engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked every rising edge outside reset
`define WFQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define WFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define WFQ_ASSERT(lbl, prop, msg)
`define WFQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/wfq_pkg.sv @@
// shared types and constants of the fair queueing tag scheduler
package wfq_pkg;

	localparam int FLOWS       = 16384;
	localparam int FLOW_W      = $clog2(FLOWS);
	localparam int QUEUE_DEPTH = 4096;
	localparam int CNT_W       = 13;
	localparam int CNT_MAX     = (1 << CNT_W) - 1;
	localparam int CNT_LIMIT   = (QUEUE_DEPTH < CNT_MAX) ? QUEUE_DEPTH : CNT_MAX;

	localparam int ACT_W    = 2;
	localparam int ID_W     = 14;
	localparam int LEN_W    = 16;
	localparam int WEIGHT_W = 16;
	localparam int TAG_W    = 32;
	localparam int FRAC_W   = 8;

	localparam logic [WEIGHT_W-1:0] DEFAULT_WEIGHT_RST = 16'd256;

	// action codes carried in the request user bits
	localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DEQ = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SET = 2'd2;

	// stream widths
	localparam int S_DATA_W = 80;
	localparam int S_USER_W = ACT_W;
	localparam int M_DATA_W = 48;
	localparam int M_USER_W = 1;

	// command queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// classified request
	typedef struct packed {
		logic                is_enq;
		logic                is_deq;
		logic                is_set;
		logic [FLOW_W-1:0]   flow;
		logic [LEN_W-1:0]    pkt_len;
		logic [TAG_W-1:0]    dprio;
		logic [WEIGHT_W-1:0] new_weight;
		logic                keep;
	} cmd_t;

	// one flow table entry
	typedef struct packed {
		logic                valid;
		logic [WEIGHT_W-1:0] weight;
		logic [TAG_W-1:0]    finish;
		logic [CNT_W-1:0]    count;
		logic                persist;
	} entry_t;

endpackage

@@ hdl/wfq_start_tag_scheduler_core.sv @@
// top level of the weighted fair queueing start tag scheduler
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+------------------------------------------
//  s        | in  | s_tvalid / s_tready   | tuser action, tdata flow/len/prio/weight/keep
//  m        | out | m_tvalid / m_tready   | tuser status, tdata priority_res/flow_pending
//  cfg      | in  | cfg_we                | cfg_wdata weight of flows made by enqueue
//
// each request takes two steps in the table engine: a read of the flow
// entry from the single-port flow memory, then an update and write-back.
// an accepted request is registered in the intake stage before it enters the
// queue; the result register loads at the write-back edge, raising m_tvalid.
// after reset the flow memory is cleared one entry a cycle, all 16384 entries;
// s_tready stays low during that sweep.
// a stalled result stalls the engine; intake keeps filling the four-deep queue.
module wfq_start_tag_scheduler_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// flow_id, pkt_len, dequeued_prio, new_weight, keep_flow, zero pad
	input  logic [wfq_pkg::S_DATA_W-1:0]  s_tdata,
	// action
	input  logic [wfq_pkg::S_USER_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// priority_res, flow_pending, zero pad
	output logic [wfq_pkg::M_DATA_W-1:0]  m_tdata,
	// status
	output logic [wfq_pkg::M_USER_W-1:0]  m_tuser,
	input  logic                          cfg_we,
	input  logic [wfq_pkg::WEIGHT_W-1:0]  cfg_wdata
);

	logic [wfq_pkg::WEIGHT_W-1:0] dflt_weight_q;
	logic                         init_busy;
	logic                         push_valid;
	logic                         push_ready;
	wfq_pkg::cmd_t                push_cmd;
	logic                         head_valid;
	wfq_pkg::cmd_t                head_cmd;
	logic                         pop;

	// default weight register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_weight_q <= wfq_pkg::DEFAULT_WEIGHT_RST;
		end else if (cfg_we) begin
			dflt_weight_q <= cfg_wdata;
		end
	end

	wfq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.init_busy  (init_busy),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_cmd   (push_cmd)
	);

	wfq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	wfq_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_cmd       (head_cmd),
		.pop            (pop),
		.base_weight    (dflt_weight_q),
		.init_busy      (init_busy),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser)
	);

endmodule

@@ hdl/wfq_front.sv @@
// request intake: decodes the action and stages one classified command
module wfq_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// flow_id, pkt_len, dequeued_prio, new_weight, keep_flow, zero pad
	input  logic [wfq_pkg::S_DATA_W-1:0]  s_tdata,
	// action
	input  logic [wfq_pkg::S_USER_W-1:0]  s_tuser,
	input  logic                          init_busy,
	input  logic                          push_ready,
	output logic                          push_valid,
	output wfq_pkg::cmd_t                 push_cmd
);

	logic          v_s1;
	wfq_pkg::cmd_t cmd_s1;
	wfq_pkg::cmd_t dec;
	logic          take;

	// field decode
	always_comb begin
		dec.is_enq     = (s_tuser == wfq_pkg::ACT_ENQ);
		dec.is_deq     = (s_tuser == wfq_pkg::ACT_DEQ);
		dec.is_set     = (s_tuser == wfq_pkg::ACT_SET);
		dec.flow       = wfq_pkg::FLOW_W'(s_tdata[13:0]);
		dec.pkt_len    = s_tdata[29:14];
		dec.dprio      = s_tdata[61:30];
		dec.new_weight = s_tdata[77:62];
		dec.keep       = s_tdata[78];
	end

	assign s_tready   = !init_busy && (!v_s1 || push_ready);
	assign take       = s_tvalid && s_tready;
	assign push_valid = v_s1;
	assign push_cmd   = cmd_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= dec;
		end
	end

endmodule

@@ hdl/wfq_fifo.sv @@
// short command queue between intake and table engine
module wfq_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  wfq_pkg::cmd_t push_cmd,
	output logic          head_valid,
	output wfq_pkg::cmd_t head_cmd,
	input  logic          pop
);

	wfq_pkg::cmd_t                slot_q [wfq_pkg::FIFO_DEPTH];
	logic [wfq_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [wfq_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [wfq_pkg::FIFO_AW:0]    cnt_q;
	logic                         push;

	assign push_ready = (cnt_q != (wfq_pkg::FIFO_AW+1)'(wfq_pkg::FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ hdl/wfq_back.sv @@
// flow table engine: read-modify-write of one entry per command
`include "assert_macros.svh"

module wfq_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                head_valid,
	input  wfq_pkg::cmd_t                       head_cmd,
	output logic                                pop,
	input  logic [wfq_pkg::WEIGHT_W-1:0]        base_weight,
	output logic                                init_busy,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// priority_res, flow_pending, zero pad
	output logic [wfq_pkg::M_DATA_W-1:0]        m_tdata,
	// status
	output logic [wfq_pkg::M_USER_W-1:0]        m_tuser
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EX   = 2'd1;

	wfq_pkg::entry_t                 mem [wfq_pkg::FLOWS];
	wfq_pkg::entry_t                 rdata_q;
	wfq_pkg::entry_t                 nxt;
	wfq_pkg::entry_t                 zero_entry;
	wfq_pkg::cmd_t                   cmd_q;
	logic [1:0]                      state_q;
	logic                            clr_busy_q;
	logic [wfq_pkg::FLOW_W-1:0]      clr_idx_q;
	logic [wfq_pkg::TAG_W-1:0]       vt_q;
	logic                            out_v_q;
	logic [wfq_pkg::TAG_W-1:0]       out_prio_q;
	logic [wfq_pkg::CNT_W-1:0]       out_pend_q;
	logic                            out_stat_q;
	logic                            wr_en;
	logic                            vt_we;
	logic                            status;
	logic [wfq_pkg::TAG_W-1:0]       prio;
	logic [wfq_pkg::TAG_W-1:0]       start;
	logic [wfq_pkg::TAG_W-1:0]       prod;
	logic [wfq_pkg::CNT_W-1:0]       pend;

	assign zero_entry = '0;
	assign init_busy  = clr_busy_q;
	assign pop        = (state_q == ST_IDLE) && !clr_busy_q && head_valid
	                    && (!out_v_q || m_tready);
	assign wr_en      = (state_q == ST_EX);

	// entry update for the command in flight
	always_comb begin
		nxt    = rdata_q;
		status = 1'b0;
		prio   = '0;
		vt_we  = 1'b0;
		start  = '0;
		prod   = '0;
		if (cmd_q.is_enq) begin
			if (!rdata_q.valid) begin
				nxt.valid   = 1'b1;
				nxt.weight  = base_weight;
				nxt.finish  = '0;
				nxt.count   = '0;
				nxt.persist = 1'b0;
			end
			if (nxt.count < wfq_pkg::CNT_W'(wfq_pkg::CNT_LIMIT)) begin
				nxt.count = nxt.count + 1'b1;
			end
			start = (nxt.finish > vt_q) ? nxt.finish : vt_q;
			prod  = cmd_q.pkt_len * nxt.weight;
			nxt.finish = start + wfq_pkg::TAG_W'(prod[wfq_pkg::TAG_W-1:wfq_pkg::FRAC_W]);
			prio  = start;
		end else if (cmd_q.is_deq) begin
			if (!rdata_q.valid) begin
				status = 1'b1;
			end else begin
				if (nxt.count != '0) begin
					nxt.count = nxt.count - 1'b1;
				end
				if (nxt.count == '0) begin
					if (!nxt.persist) begin
						nxt.valid = 1'b0;
					end else begin
						nxt.finish = '0;
					end
				end
				vt_we = 1'b1;
			end
		end else if (cmd_q.is_set) begin
			if (!rdata_q.valid) begin
				nxt.valid  = 1'b1;
				nxt.finish = '0;
				nxt.count  = '0;
			end
			nxt.weight  = cmd_q.new_weight;
			nxt.persist = cmd_q.keep;
		end
		pend = nxt.valid ? nxt.count : '0;
	end

	// control: sequencer, clearing sweep, virtual time, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			vt_q       <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == wfq_pkg::FLOW_W'(wfq_pkg::FLOWS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EX;
					end
				end
				ST_EX: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (vt_we && wr_en) begin
				vt_q <= cmd_q.dprio;
			end
			if (wr_en) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
		end
		if (wr_en) begin
			out_prio_q <= prio;
			out_pend_q <= pend;
			out_stat_q <= status;
		end
	end

	// flow table: one write port, registered read
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= zero_entry;
		end else if (wr_en) begin
			mem[cmd_q.flow] <= nxt;
		end
		if (pop) begin
			rdata_q <= mem[head_cmd.flow];
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'b000, out_pend_q, out_prio_q};
	assign m_tuser  = out_stat_q;

	// checks
	`WFQ_ASSERT(a_ex_out_free, (state_q != ST_EX) || !out_v_q, "result register busy on update")
	`WFQ_ASSERT(a_no_pop_clear, !(pop && clr_busy_q), "command taken during table clear")
	`WFQ_ASSERT_NEXT(a_vt_update, vt_we && wr_en, vt_q == $past(cmd_q.dprio), "stale virtual time")
	`WFQ_ASSERT_NEXT(a_one_rmw, pop, (state_q == ST_EX) && !pop, "overlapping table updates")

endmodule
